FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the lottery scheduler checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is held
`define LTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is held
`define LTS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// types and constants shared by the lottery ticket scheduler
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int RND_W = 31;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DRAW   = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic             op;
		logic [15:0]      ticket_count;
		logic [RND_W-1:0] random_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  winner_slot;
		logic [19:0] drawn_ticket;
		logic [15:0] winner_tickets;
		logic [19:0] ticket_total;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_PRIME,
		S_WALK,
		S_DONE
	} state_t;

endpackage

FILE: sv/lottery_ticket_scheduler_top.sv
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_top
// lottery scheduler: job ticket table, running total and winner draw
// ----------------------------------------------------------------------------
// usage
// - request channel req / req_valid / req_stall: op insert adds a job with
//   ticket_count in the next free slot, op draw picks a winner using
//   random_value
// - response channel rsp / rsp_valid / rsp_stall: one transaction per request
// - insert, full table and empty draw finish in the accepting cycle; the
//   response is visible on the next cycle
// - a draw with tickets runs the modulo unit (one dividend bit per cycle),
//   primes the table read in S_PRIME, then walks the table newest to oldest
//   at one entry per cycle through the single ram read port
// - the block holds req_stall high while a draw is at work, so one request
//   is in flight at a time
// - the response sits in an output register; a new request is taken while
//   it waits only if the register frees in the same cycle
// - reset empties the table (job count and total cleared); ram contents are
//   not cleared, entries at or above the job count are never read
// - while rsp_stall is high the response holds and a finished draw waits
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler_top #(
	parameter int MAX_JOBS    = 16,
	parameter int TICKET_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lts_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lts_pkg::rsp_t rsp
);

	// widths that follow from the table size and ticket width
	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int TOT_W = TICKET_BITS + IDX_W;

	// control state
	lts_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] job_cnt_q;
	logic [TOT_W-1:0] total_q;
	logic             rsp_valid_q;

	// draw working registers
	logic [TOT_W-1:0]       win_q;
	logic [TOT_W-1:0]       sum_q;
	logic [IDX_W-1:0]       addr_q;
	logic [IDX_W-1:0]       chk_q;
	logic [IDX_W-1:0]       slot_q;
	logic [TICKET_BITS-1:0] wtix_q;
	lts_pkg::rsp_t          rsp_q;

	// handshake and datapath nets
	logic                   out_free;
	logic                   accept;
	logic                   is_draw;
	logic                   tot_zero;
	logic                   full;
	logic [TICKET_BITS-1:0] tix;
	logic [TOT_W-1:0]       total_ins;
	logic                   mod_start;
	logic                   mod_done;
	logic [TOT_W-1:0]       mod_rem;
	logic                   ram_we;
	logic [TICKET_BITS-1:0] rd_data;
	logic [TOT_W-1:0]       sum_nx;
	logic                   hit;
	logic                   rsp_load;
	lts_pkg::rsp_t          rsp_d;

	// output register is free when empty or being taken this edge
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign accept   = req_valid && !req_stall;
	assign is_draw  = req.op == lts_pkg::OP_DRAW;
	assign tot_zero = total_q == '0;
	assign full     = job_cnt_q == CNT_W'(MAX_JOBS);
	assign tix      = TICKET_BITS'(req.ticket_count);
	assign total_ins = total_q + TOT_W'(tix);

	// table walk: running sum against the winning ticket
	assign sum_nx = sum_q + TOT_W'(rd_data);
	assign hit    = sum_nx >= win_q;

	lts_mod #(
		.DIV_W(TOT_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(req.random_value),
		.divisor (total_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	lts_ram #(
		.WIDTH(TICKET_BITS),
		.DEPTH(MAX_JOBS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(job_cnt_q[IDX_W-1:0]),
		.wdata(tix),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lts_pkg::S_IDLE: begin
				if (accept && is_draw && !tot_zero) begin
					state_d = lts_pkg::S_DIV;
				end
			end
			lts_pkg::S_DIV: begin
				if (mod_done) begin
					state_d = lts_pkg::S_PRIME;
				end
			end
			lts_pkg::S_PRIME: begin
				state_d = lts_pkg::S_WALK;
			end
			lts_pkg::S_WALK: begin
				if (hit || chk_q == '0) begin
					state_d = lts_pkg::S_DONE;
				end
			end
			lts_pkg::S_DONE: begin
				if (out_free) begin
					state_d = lts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lts_pkg::S_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		req_stall = 1'b1;
		mod_start = 1'b0;
		ram_we    = 1'b0;
		rsp_load  = 1'b0;
		rsp_d     = '0;
		case (state_q)
			lts_pkg::S_IDLE: begin
				req_stall = !out_free;
				if (accept) begin
					if (!is_draw) begin
						// insert, or full table with the total unchanged
						rsp_load = 1'b1;
						if (full) begin
							rsp_d.status       = lts_pkg::ST_FULL;
							rsp_d.ticket_total = 20'(total_q);
						end else begin
							ram_we             = 1'b1;
							rsp_d.status       = lts_pkg::ST_OK;
							rsp_d.ticket_total = 20'(total_ins);
						end
					end else if (tot_zero) begin
						// draw with no tickets: all other fields zero
						rsp_load     = 1'b1;
						rsp_d.status = lts_pkg::ST_EMPTY;
					end else begin
						mod_start = 1'b1;
					end
				end
			end
			lts_pkg::S_DONE: begin
				rsp_load             = out_free;
				rsp_d.status         = lts_pkg::ST_OK;
				rsp_d.winner_slot    = 4'(slot_q);
				rsp_d.drawn_ticket   = 20'(win_q);
				rsp_d.winner_tickets = 16'(wtix_q);
				rsp_d.ticket_total   = 20'(total_q);
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lts_pkg::S_IDLE;
			job_cnt_q   <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				job_cnt_q <= job_cnt_q + 1'b1;
				total_q   <= total_ins;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// draw datapath and response payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		case (state_q)
			lts_pkg::S_DIV: begin
				if (mod_done) begin
					// winning ticket is remainder plus one, walk starts at newest job
					win_q  <= mod_rem + 1'b1;
					addr_q <= IDX_W'(job_cnt_q - 1'b1);
				end
			end
			lts_pkg::S_PRIME: begin
				sum_q  <= '0;
				chk_q  <= addr_q;
				addr_q <= addr_q - 1'b1;
			end
			lts_pkg::S_WALK: begin
				sum_q <= sum_nx;
				if (hit) begin
					slot_q <= chk_q;
					wtix_q <= rd_data;
				end else if (chk_q == '0) begin
					slot_q <= '0;
					wtix_q <= '0;
				end else begin
					chk_q  <= addr_q;
					addr_q <= addr_q - 1'b1;
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sv/lts_ram.sv
// ----------------------------------------------------------------------------
// lts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/lts_mod.sv
// ----------------------------------------------------------------------------
// lts_mod
// restoring modulo unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module lts_mod #(
	parameter int DIV_W = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lts_pkg::RND_W-1:0] dividend,
	input  logic [DIV_W-1:0]          divisor,
	output logic                      done,
	output logic [DIV_W-1:0]          rem
);

	localparam int STEP_W = $clog2(lts_pkg::RND_W);

	logic                      busy_q;
	logic                      done_q;
	logic [STEP_W-1:0]         cnt_q;
	logic [lts_pkg::RND_W-1:0] dvd_q;
	logic [DIV_W-1:0]          dvs_q;
	logic [DIV_W-1:0]          rem_q;

	logic [DIV_W:0]   trial;
	logic             ge;
	logic [DIV_W-1:0] rem_nx;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial  = {rem_q, dvd_q[lts_pkg::RND_W-1]};
		ge     = trial >= {1'b0, dvs_q};
		rem_nx = ge ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(lts_pkg::RND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: sv/lts_checker.sv
// ----------------------------------------------------------------------------
// lts_checker
// port level checks for the lottery ticket scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input lts_pkg::rsp_t rsp
);

	// a stalled response transaction holds
	`LTS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response changed while stalled")

	// no response transaction while reset is held
	`LTS_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rsp_valid, "response valid during reset")

	// full table reports no winner
	`LTS_ASSERT(a_full_zero, rsp_valid && rsp.status == lts_pkg::ST_FULL |-> rsp.drawn_ticket == '0 && rsp.winner_slot == '0 && rsp.winner_tickets == '0, "full table response carries winner data")

	// empty draw reports zero total, drawn ticket and winner tickets
	`LTS_ASSERT(a_empty_zero, rsp_valid && rsp.status == lts_pkg::ST_EMPTY |-> rsp.ticket_total == '0 && rsp.drawn_ticket == '0 && rsp.winner_tickets == '0, "empty draw response not zero")

	// a drawn winner always holds tickets
	`LTS_ASSERT(a_winner_tix, rsp_valid && rsp.status == lts_pkg::ST_OK && rsp.drawn_ticket != '0 |-> rsp.winner_tickets != '0, "winner holds no tickets")

endmodule

bind lottery_ticket_scheduler_top lts_checker u_lts_checker (.*);
